/* hw/rtl/joystick_to_gamepad_report_top_assert.svh */
// Assertion macros for the joystick to gamepad report block.
`ifndef JOYSTICK_TO_GAMEPAD_REPORT_TOP_ASSERT_SVH
`define JOYSTICK_TO_GAMEPAD_REPORT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define JTG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jtg assertion failed");
// Next-cycle implication, checked out of reset.
`define JTG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jtg assertion failed");
`else
`define JTG_ASSERT_NOW(label, ante, cons)
`define JTG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/jtg_pkg.sv */
// Types, constants and helper functions for the joystick to gamepad report block.
package jtg_pkg;

  typedef struct packed {
    logic [11:0]        pressed_flags;
    logic               hat_centered;
    logic [15:0]        hat_angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] axis_rx;
    logic signed [15:0] axis_ry;
    logic signed [15:0] axis_rz;
  } sample_t;

  // Report body: everything that takes part in change detection.
  typedef struct packed {
    logic [15:0]        button_bits;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic signed [15:0] thumb_lx;
    logic signed [15:0] thumb_ly;
    logic signed [15:0] thumb_rx;
    logic signed [15:0] thumb_ry;
  } report_t;

  // Joystick button numbers
  localparam int unsigned JoyBtnX         = 0;
  localparam int unsigned JoyBtnA         = 1;
  localparam int unsigned JoyBtnB         = 2;
  localparam int unsigned JoyBtnY         = 3;
  localparam int unsigned JoyBtnLShoulder = 4;
  localparam int unsigned JoyBtnRShoulder = 5;
  localparam int unsigned JoyBtnLTrigger  = 6;
  localparam int unsigned JoyBtnRTrigger  = 7;
  localparam int unsigned JoyBtnBack      = 8;
  localparam int unsigned JoyBtnStart     = 9;
  localparam int unsigned JoyBtnLThumb    = 10;
  localparam int unsigned JoyBtnRThumb    = 11;

  // Gamepad button word bit positions
  localparam int unsigned PadDpadUp     = 0;
  localparam int unsigned PadDpadDown   = 1;
  localparam int unsigned PadDpadLeft   = 2;
  localparam int unsigned PadDpadRight  = 3;
  localparam int unsigned PadStart      = 4;
  localparam int unsigned PadBack       = 5;
  localparam int unsigned PadLThumb     = 6;
  localparam int unsigned PadRThumb     = 7;
  localparam int unsigned PadLShoulder  = 8;
  localparam int unsigned PadRShoulder  = 9;
  localparam int unsigned PadA          = 12;
  localparam int unsigned PadB          = 13;
  localparam int unsigned PadX          = 14;
  localparam int unsigned PadY          = 15;

  // Hat sector bounds, hundredths of a degree, inclusive
  localparam logic [15:0] HatRightLo = 16'd4500;
  localparam logic [15:0] HatDownLo  = 16'd13500;
  localparam logic [15:0] HatLeftLo  = 16'd22500;
  localparam logic [15:0] HatUpLo    = 16'd31500;

  localparam logic [7:0]         TrigFull   = 8'd255;
  localparam logic signed [16:0] AxisFull   = 17'sd32767;
  localparam logic signed [15:0] AxisMin    = 16'sh8000;
  localparam logic signed [15:0] AxisMax    = 16'sh7FFF;
  localparam logic [15:0]        ScaleDiv   = 16'd32767;

  // floor(v*255/32767) clamped to 0..255. Divide by 2^15-1: estimate with
  // a shift, then one correction step since the remainder stays below 2x.
  function automatic logic [7:0] trig_level(input logic signed [16:0] v);
    logic [14:0] m;
    logic [22:0] x;
    logic [7:0]  q;
    logic [15:0] r;
    m = v[14:0];
    x = {m, 8'b0} - {8'b0, m};
    q = x[22:15];
    r = {1'b0, x[14:0]} + {8'b0, q};
    if (v <= 17'sd0) begin
      trig_level = 8'd0;
    end else if (v >= AxisFull) begin
      trig_level = TrigFull;
    end else if (r >= ScaleDiv) begin
      trig_level = q + 8'd1;
    end else begin
      trig_level = q;
    end
  endfunction

  // Negate a stick axis, saturating the one value with no positive twin.
  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    neg_sat = (v == AxisMin) ? AxisMax : -v;
  endfunction

endpackage

/* hw/rtl/jtg_if.sv */
// Valid/ready channel interfaces for joystick samples and gamepad reports.
interface jtg_sample_if;
  logic               valid;
  logic               ready;
  logic [11:0]        pressed_flags;
  logic               hat_centered;
  logic [15:0]        hat_angle;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic signed [15:0] axis_rx;
  logic signed [15:0] axis_ry;
  logic signed [15:0] axis_rz;

  modport source (
    output valid, pressed_flags, hat_centered, hat_angle,
    output axis_x, axis_y, axis_z, axis_rx, axis_ry, axis_rz,
    input  ready
  );
  modport sink (
    input  valid, pressed_flags, hat_centered, hat_angle,
    input  axis_x, axis_y, axis_z, axis_rx, axis_ry, axis_rz,
    output ready
  );
endinterface

interface jtg_report_if;
  logic               valid;
  logic               ready;
  logic [15:0]        button_bits;
  logic [7:0]         left_trigger;
  logic [7:0]         right_trigger;
  logic signed [15:0] thumb_lx;
  logic signed [15:0] thumb_ly;
  logic signed [15:0] thumb_rx;
  logic signed [15:0] thumb_ry;
  logic [31:0]        packet_number;

  modport source (
    output valid, button_bits, left_trigger, right_trigger,
    output thumb_lx, thumb_ly, thumb_rx, thumb_ry, packet_number,
    input  ready
  );
  modport sink (
    input  valid, button_bits, left_trigger, right_trigger,
    input  thumb_lx, thumb_ly, thumb_rx, thumb_ry, packet_number,
    output ready
  );
endinterface

/* hw/rtl/joystick_to_gamepad_report_top.sv */
// Joystick sample to gamepad report converter, top level.
// Turns each joystick sample into exactly one gamepad report. A sample passes
// an input register, one level of mapping logic (button remap, hat sectors,
// trigger scaling by 255/32767 with a shift-and-correct divide, Y negation
// with saturation) and the result register. A report is loaded into the
// result register when it is empty or its report is taken, and is offered
// from then on. One sample per cycle is sustained while the report side is
// ready; the result register compares each report with the one before it
// and bumps the 32-bit packet number on any difference (first vs. all zeros).
`include "joystick_to_gamepad_report_top_assert.svh"

module joystick_to_gamepad_report_top (
  input  logic          clk,
  input  logic          rst,
  jtg_sample_if.sink    sample,
  jtg_report_if.source  report
);

  jtg_pkg::sample_t stage_data;
  jtg_pkg::report_t stage_body;
  logic             stage_valid;
  logic             stage_take;

  jtg_in_stage u_in_stage (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .take   (stage_take),
    .valid  (stage_valid),
    .data   (stage_data)
  );

  jtg_map u_map (
    .s (stage_data),
    .r (stage_body)
  );

  jtg_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stage_valid),
    .body     (stage_body),
    .take     (stage_take),
    .report   (report)
  );

  `JTG_ASSERT_NEXT(a_load_shows_result, stage_take, report.valid)
  `JTG_ASSERT_NEXT(a_packet_step, stage_take,
                   (report.packet_number - $past(report.packet_number)) <= 32'd1)
  `JTG_ASSERT_NOW(a_stall_means_full, !sample.ready, stage_valid && report.valid && !report.ready)
  `JTG_ASSERT_NOW(a_reserved_bits_zero, report.valid, report.button_bits[11:10] == 2'b00)

endmodule

/* hw/rtl/jtg_in_stage.sv */
// Input register stage: captures one joystick sample per transaction.
module jtg_in_stage (
  input  logic              clk,
  input  logic              rst,
  jtg_sample_if.sink        sample,
  input  logic              take,
  output logic              valid,
  output jtg_pkg::sample_t  data
);

  assign sample.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sample.ready) begin
      valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      data.pressed_flags <= sample.pressed_flags;
      data.hat_centered  <= sample.hat_centered;
      data.hat_angle     <= sample.hat_angle;
      data.axis_x        <= sample.axis_x;
      data.axis_y        <= sample.axis_y;
      data.axis_z        <= sample.axis_z;
      data.axis_rx       <= sample.axis_rx;
      data.axis_ry       <= sample.axis_ry;
      data.axis_rz       <= sample.axis_rz;
    end
  end

endmodule

/* hw/rtl/jtg_map.sv */
// Sample to report mapping: button remap, hat sectors, triggers and sticks.
module jtg_map (
  input  jtg_pkg::sample_t  s,
  output jtg_pkg::report_t  r
);

  logic [15:0] btn;
  logic [7:0]  lt;
  logic [7:0]  rt;
  logic [7:0]  lvl_neg_z;
  logic [7:0]  lvl_z;
  logic [7:0]  lvl_rz;

  assign lvl_neg_z = jtg_pkg::trig_level(-$signed({s.axis_z[15], s.axis_z}));
  assign lvl_z     = jtg_pkg::trig_level($signed({s.axis_z[15], s.axis_z}));
  assign lvl_rz    = jtg_pkg::trig_level($signed({s.axis_rz[15], s.axis_rz}));

  always_comb begin
    btn = '0;
    btn[jtg_pkg::PadA]         = s.pressed_flags[jtg_pkg::JoyBtnA];
    btn[jtg_pkg::PadB]         = s.pressed_flags[jtg_pkg::JoyBtnB];
    btn[jtg_pkg::PadX]         = s.pressed_flags[jtg_pkg::JoyBtnX];
    btn[jtg_pkg::PadY]         = s.pressed_flags[jtg_pkg::JoyBtnY];
    btn[jtg_pkg::PadLShoulder] = s.pressed_flags[jtg_pkg::JoyBtnLShoulder];
    btn[jtg_pkg::PadRShoulder] = s.pressed_flags[jtg_pkg::JoyBtnRShoulder];
    btn[jtg_pkg::PadBack]      = s.pressed_flags[jtg_pkg::JoyBtnBack];
    btn[jtg_pkg::PadStart]     = s.pressed_flags[jtg_pkg::JoyBtnStart];
    btn[jtg_pkg::PadLThumb]    = s.pressed_flags[jtg_pkg::JoyBtnLThumb];
    btn[jtg_pkg::PadRThumb]    = s.pressed_flags[jtg_pkg::JoyBtnRThumb];
    // sectors overlap at their bounds; out-of-range angles land in "up"
    if (!s.hat_centered) begin
      btn[jtg_pkg::PadDpadUp]    = (s.hat_angle >= jtg_pkg::HatUpLo) ||
                                   (s.hat_angle <= jtg_pkg::HatRightLo);
      btn[jtg_pkg::PadDpadRight] = (s.hat_angle >= jtg_pkg::HatRightLo) &&
                                   (s.hat_angle <= jtg_pkg::HatDownLo);
      btn[jtg_pkg::PadDpadDown]  = (s.hat_angle >= jtg_pkg::HatDownLo) &&
                                   (s.hat_angle <= jtg_pkg::HatLeftLo);
      btn[jtg_pkg::PadDpadLeft]  = (s.hat_angle >= jtg_pkg::HatLeftLo) &&
                                   (s.hat_angle <= jtg_pkg::HatUpLo);
    end
  end

  always_comb begin
    if (s.pressed_flags[jtg_pkg::JoyBtnLTrigger] || s.pressed_flags[jtg_pkg::JoyBtnRTrigger]) begin
      lt = s.pressed_flags[jtg_pkg::JoyBtnLTrigger] ? jtg_pkg::TrigFull : 8'd0;
      rt = s.pressed_flags[jtg_pkg::JoyBtnRTrigger] ? jtg_pkg::TrigFull : 8'd0;
    end else begin
      lt = lvl_neg_z;
      rt = (lvl_z != 8'd0) ? lvl_z : lvl_rz;
    end
  end

  always_comb begin
    r.button_bits   = btn;
    r.left_trigger  = lt;
    r.right_trigger = rt;
    r.thumb_lx      = s.axis_x;
    r.thumb_ly      = jtg_pkg::neg_sat(s.axis_y);
    r.thumb_rx      = s.axis_rx;
    r.thumb_ry      = jtg_pkg::neg_sat(s.axis_ry);
  end

endmodule

/* hw/rtl/jtg_out_stage.sv */
// Result register stage with change detection and packet counter.
module jtg_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  jtg_pkg::report_t  body,
  output logic              take,
  jtg_report_if.source      report
);

  // body_q doubles as the previous report, so it resets to all zeros
  jtg_pkg::report_t body_q;
  logic             valid;
  logic [31:0]      packet;
  logic [31:0]      packet_next;

  assign take        = in_valid && (!valid || report.ready);
  assign packet_next = (body != body_q) ? packet + 32'd1 : packet;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      packet <= '0;
      body_q <= '0;
    end else if (take) begin
      valid  <= 1'b1;
      packet <= packet_next;
      body_q <= body;
    end else if (report.ready) begin
      valid  <= 1'b0;
    end
  end

  assign report.valid         = valid;
  assign report.button_bits   = body_q.button_bits;
  assign report.left_trigger  = body_q.left_trigger;
  assign report.right_trigger = body_q.right_trigger;
  assign report.thumb_lx      = body_q.thumb_lx;
  assign report.thumb_ly      = body_q.thumb_ly;
  assign report.thumb_rx      = body_q.thumb_rx;
  assign report.thumb_ry      = body_q.thumb_ry;
  assign report.packet_number = packet;

endmodule

/* bench/joystick_to_gamepad_report_top_tb.sv */
// Testbench for the joystick to gamepad report block: directed and random samples, predicted reports.
`timescale 1ns / 1ps

module joystick_to_gamepad_report_top_tb;
  import jtg_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int MaxShown   = 10;
  localparam int PhaseItems = 460;

  typedef struct {
    report_t     body;
    logic [31:0] packet_number;
  } expected_report_t;

  // Predicts each report from the accepted samples and checks the reports in order.
  class report_tracker;
    expected_report_t pending_reports[$];
    report_t          last_body;
    logic [31:0]      change_count;
    int               mismatches;

    function new();
      last_body    = '0;
      change_count = '0;
      mismatches   = 0;
    endfunction

    static function int widen(logic [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    static function logic [7:0] trigger_from_axis(int v);
      if (v <= 0) return 8'd0;
      if (v >= 32767) return 8'd255;
      return 8'((v * 255) / 32767);
    endfunction

    static function logic [15:0] flip_axis(logic [15:0] v);
      int n;
      n = -widen(v);
      if (n > 32767) n = 32767;
      return 16'(n);
    endfunction

    function report_t map_sample(sample_t s);
      report_t     r;
      logic [15:0] ang;
      r = '0;
      r.button_bits[PadX]         = s.pressed_flags[JoyBtnX];
      r.button_bits[PadA]         = s.pressed_flags[JoyBtnA];
      r.button_bits[PadB]         = s.pressed_flags[JoyBtnB];
      r.button_bits[PadY]         = s.pressed_flags[JoyBtnY];
      r.button_bits[PadLShoulder] = s.pressed_flags[JoyBtnLShoulder];
      r.button_bits[PadRShoulder] = s.pressed_flags[JoyBtnRShoulder];
      r.button_bits[PadBack]      = s.pressed_flags[JoyBtnBack];
      r.button_bits[PadStart]     = s.pressed_flags[JoyBtnStart];
      r.button_bits[PadLThumb]    = s.pressed_flags[JoyBtnLThumb];
      r.button_bits[PadRThumb]    = s.pressed_flags[JoyBtnRThumb];
      ang = s.hat_angle;
      if (!s.hat_centered) begin
        // sectors overlap at their inclusive bounds
        r.button_bits[PadDpadUp]    = (ang >= HatUpLo) || (ang <= HatRightLo);
        r.button_bits[PadDpadRight] = (ang >= HatRightLo) && (ang <= HatDownLo);
        r.button_bits[PadDpadDown]  = (ang >= HatDownLo) && (ang <= HatLeftLo);
        r.button_bits[PadDpadLeft]  = (ang >= HatLeftLo) && (ang <= HatUpLo);
      end
      if (s.pressed_flags[JoyBtnLTrigger] || s.pressed_flags[JoyBtnRTrigger]) begin
        r.left_trigger  = s.pressed_flags[JoyBtnLTrigger] ? 8'd255 : 8'd0;
        r.right_trigger = s.pressed_flags[JoyBtnRTrigger] ? 8'd255 : 8'd0;
      end else begin
        r.left_trigger  = trigger_from_axis(-widen(s.axis_z));
        r.right_trigger = trigger_from_axis(widen(s.axis_z));
        if (r.right_trigger == 8'd0) r.right_trigger = trigger_from_axis(widen(s.axis_rz));
      end
      r.thumb_lx = s.axis_x;
      r.thumb_ly = flip_axis(s.axis_y);
      r.thumb_rx = s.axis_rx;
      r.thumb_ry = flip_axis(s.axis_ry);
      return r;
    endfunction

    function void take_sample(sample_t s);
      expected_report_t e;
      e.body = map_sample(s);
      if (e.body != last_body) change_count = change_count + 32'd1;
      last_body = e.body;
      e.packet_number = change_count;
      pending_reports.insert(pending_reports.size(), e);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, field, want, got);
      end
    endfunction

    function void check_report(report_t got, logic [31:0] got_number);
      expected_report_t want;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("%0t: report with none expected, packet %0h", $realtime, got_number);
        return;
      end
      want = pending_reports.pop_front();
      compare("button_bits", want.body.button_bits, got.button_bits);
      compare("left_trigger", want.body.left_trigger, got.left_trigger);
      compare("right_trigger", want.body.right_trigger, got.right_trigger);
      compare("thumb_lx", want.body.thumb_lx, got.thumb_lx);
      compare("thumb_ly", want.body.thumb_ly, got.thumb_ly);
      compare("thumb_rx", want.body.thumb_rx, got.thumb_rx);
      compare("thumb_ry", want.body.thumb_ry, got.thumb_ry);
      compare("packet_number", want.packet_number, got_number);
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  jtg_sample_if sample_ch ();
  jtg_report_if report_ch ();

  joystick_to_gamepad_report_top dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch.sink),
    .report (report_ch.source)
  );

  report_tracker tracker;
  int            src_idle_pct   = 0;
  int            sink_stall_pct = 0;
  int unsigned   cycle_count    = 0;
  sample_t       last_sent;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    report_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Values read here are the ones present just before the edge.
  always @(posedge clk) begin
    sample_t seen;
    report_t got;
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready) begin
        seen.pressed_flags = sample_ch.pressed_flags;
        seen.hat_centered  = sample_ch.hat_centered;
        seen.hat_angle     = sample_ch.hat_angle;
        seen.axis_x        = sample_ch.axis_x;
        seen.axis_y        = sample_ch.axis_y;
        seen.axis_z        = sample_ch.axis_z;
        seen.axis_rx       = sample_ch.axis_rx;
        seen.axis_ry       = sample_ch.axis_ry;
        seen.axis_rz       = sample_ch.axis_rz;
        tracker.take_sample(seen);
      end
      if (report_ch.valid && report_ch.ready) begin
        got.button_bits   = report_ch.button_bits;
        got.left_trigger  = report_ch.left_trigger;
        got.right_trigger = report_ch.right_trigger;
        got.thumb_lx      = report_ch.thumb_lx;
        got.thumb_ly      = report_ch.thumb_ly;
        got.thumb_rx      = report_ch.thumb_rx;
        got.thumb_ry      = report_ch.thumb_ry;
        tracker.check_report(got, report_ch.packet_number);
      end
    end
  end

  task automatic put_fields(sample_t s);
    sample_ch.pressed_flags <= s.pressed_flags;
    sample_ch.hat_centered  <= s.hat_centered;
    sample_ch.hat_angle     <= s.hat_angle;
    sample_ch.axis_x        <= s.axis_x;
    sample_ch.axis_y        <= s.axis_y;
    sample_ch.axis_z        <= s.axis_z;
    sample_ch.axis_rx       <= s.axis_rx;
    sample_ch.axis_ry       <= s.axis_ry;
    sample_ch.axis_rz       <= s.axis_rz;
  endtask

  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    put_fields(s);
    sample_ch.valid <= 1'b1;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    last_sent = s;
  endtask

  task automatic send_fields(logic [11:0] flags, logic centered, logic [15:0] ang,
                             int x, int y, int z, int rx, int ry, int rz);
    sample_t s;
    s.pressed_flags = flags;
    s.hat_centered  = centered;
    s.hat_angle     = ang;
    s.axis_x        = x[15:0];
    s.axis_y        = y[15:0];
    s.axis_z        = z[15:0];
    s.axis_rx       = rx[15:0];
    s.axis_ry       = ry[15:0];
    s.axis_rz       = rz[15:0];
    send_sample(s);
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h8001;
      3: return 16'($urandom_range(260)) - 16'd130;  // around the first trigger step
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    logic [15:0] bound;
    case ($urandom_range(9))
      0: return 16'($urandom);
      1, 2: begin
        case ($urandom_range(5))
          0: bound = HatRightLo;
          1: bound = HatDownLo;
          2: bound = HatLeftLo;
          3: bound = HatUpLo;
          4: bound = 16'd0;
          default: bound = 16'd35999;
        endcase
        return bound + 16'($urandom_range(2)) - 16'd1;
      end
      default: return 16'($urandom_range(35999));
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.pressed_flags = 12'($urandom);
    // half the time leave both digital triggers up so the axes drive them
    if ($urandom_range(1) == 0) begin
      s.pressed_flags[JoyBtnLTrigger] = 1'b0;
      s.pressed_flags[JoyBtnRTrigger] = 1'b0;
    end
    s.hat_centered = ($urandom_range(3) == 0);
    s.hat_angle    = rand_angle();
    s.axis_x       = rand_axis();
    s.axis_y       = rand_axis();
    s.axis_z       = rand_axis();
    s.axis_rx      = rand_axis();
    s.axis_ry      = rand_axis();
    s.axis_rz      = rand_axis();
    return s;
  endfunction

  task automatic run_random(int count, int idle_pct, int stall_pct);
    sample_t s;
    int      pick;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      s = last_sent;
      if (pick < 15) begin
        // same sample again: the packet number must hold
      end else if (pick < 25) begin
        // touch only what the report cannot see
        if (s.hat_centered) s.hat_angle = rand_angle();
        if (s.pressed_flags[JoyBtnLTrigger] || s.pressed_flags[JoyBtnRTrigger]) begin
          s.axis_z  = rand_axis();
          s.axis_rz = rand_axis();
        end else if (!s.axis_z[15] && s.axis_z[14:0] > 15'd128) begin
          s.axis_rz = rand_axis();
        end
      end else begin
        s = rand_sample();
      end
      send_sample(s);
    end
  endtask

  initial begin
    sample_t idle_fields;
    tracker = new();
    idle_fields = '0;
    rst <= 1'b1;
    sample_ch.valid <= 1'b0;
    put_fields(idle_fields);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // all-zero report equals the reset report, then an exact repeat
    send_fields(12'h000, 1'b1, 16'd0, 0, 0, 0, 0, 0, 0);
    send_fields(12'h000, 1'b1, 16'd0, 0, 0, 0, 0, 0, 0);
    // every button, both digital triggers, Y saturation
    send_fields(12'hFFF, 1'b1, 16'd0, 32767, -32768, 0, -32768, 32767, 0);
    send_fields(12'h000, 1'b1, 16'd0, -32768, 32767, 0, 32767, -32768, 0);
    // hat sector bounds and angles past the valid range
    send_fields(12'h000, 1'b0, 16'd0, 0, 0, 0, 0, 0, 0);
    send_fields(12'h000, 1'b0, HatRightLo, 0, 0, 0, 0, 0, 0);
    send_fields(12'h000, 1'b0, HatRightLo + 16'd1, 0, 0, 0, 0, 0, 0);
    send_fields(12'h000, 1'b0, HatDownLo, 0, 0, 0, 0, 0, 0);
    send_fields(12'h000, 1'b0, HatLeftLo, 0, 0, 0, 0, 0, 0);
    send_fields(12'h000, 1'b0, HatUpLo, 0, 0, 0, 0, 0, 0);
    send_fields(12'h000, 1'b0, HatUpLo - 16'd1, 0, 0, 0, 0, 0, 0);
    send_fields(12'h000, 1'b0, 16'd35999, 0, 0, 0, 0, 0, 0);
    send_fields(12'h000, 1'b0, 16'd36000, 0, 0, 0, 0, 0, 0);
    send_fields(12'h000, 1'b0, 16'hFFFF, 0, 0, 0, 0, 0, 0);
    // one or both digital triggers held ignore the axes
    send_fields(12'h040, 1'b1, 16'd0, 0, 0, -32768, 0, 0, 32767);
    send_fields(12'h080, 1'b1, 16'd0, 0, 0, -32768, 0, 0, 32767);
    send_fields(12'h0C0, 1'b1, 16'd0, 0, 0, 32767, 0, 0, 32767);
    // analog triggers: full scale, first step, fallback to Rz
    send_fields(12'h000, 1'b1, 16'd0, 0, 0, -32768, 0, 0, 0);
    send_fields(12'h000, 1'b1, 16'd0, 0, 0, 32767, 0, 0, 0);
    send_fields(12'h000, 1'b1, 16'd0, 0, 0, 0, 0, 0, 32767);
    send_fields(12'h000, 1'b1, 16'd0, 0, 0, 128, 0, 0, -128);
    send_fields(12'h000, 1'b1, 16'd0, 0, 0, 129, 0, 0, 0);
    send_fields(12'h000, 1'b1, 16'd0, 0, 0, 1, 0, 0, 16384);
    send_fields(12'h000, 1'b1, 16'd0, 0, 0, -16384, 0, 0, 20000);
    // centered hat: a new angle leaves the report unchanged
    send_fields(12'h000, 1'b1, 16'd9000, 0, 0, -16384, 0, 0, 20000);

    run_random(PhaseItems, 0, 0);
    run_random(PhaseItems, 76, 0);
    run_random(PhaseItems, 0, 76);
    run_random(PhaseItems, 23, 23);
    sample_ch.valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
